### rtl/text_scrollback_line_buffer_core_macros.svh
// assertion macros for the text scrollback line buffer
// used by the port checker, needs nothing else
`ifndef TEXT_SCROLLBACK_LINE_BUFFER_CORE_MACROS_SVH
`define TEXT_SCROLLBACK_LINE_BUFFER_CORE_MACROS_SVH

// same-cycle implication
`define TSLB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tslb: check failed");

// next-cycle implication
`define TSLB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tslb: check failed");

`endif

### rtl/tslb_pkg.sv
// shared types and constants for the text scrollback line buffer
// no dependencies
package tslb_pkg;

    localparam int BUFFER_LINES_DEF = 16;
    localparam int LINE_COLS_DEF    = 16;
    localparam int VIEW_LINES_DEF   = 2;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        OP_RX     = 3'd0,
        OP_UP     = 3'd1,
        OP_DOWN   = 3'd2,
        OP_END    = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_READ   = 3'd5
    } t_op;

    typedef struct packed {
        logic upd;       // word accepted, apply its operation
        logic rd_issue;  // start a cell read
        logic out_load;  // read data is back and the output register is free
    } t_cmd;

endpackage

### rtl/tslb_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
module tslb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tslb_ctrl.sv
// controller: handshakes and read sequencing
// depends on tslb_pkg
module tslb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  tslb_pkg::t_op    i_op,
    input  logic             i_m_tready,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    output tslb_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        o_cmd.upd      = w_accept;
        o_cmd.rd_issue = w_accept && (i_op == tslb_pkg::OP_READ);
        o_cmd.out_load = (r_state == S_READ) && w_out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.rd_issue) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

### rtl/tslb_dpath.sv
// datapath: ring pointers, fill counts and character store
// depends on tslb_pkg and tslb_ram
module tslb_dpath #(
    parameter int BUFFER_LINES = tslb_pkg::BUFFER_LINES_DEF,
    parameter int LINE_COLS    = tslb_pkg::LINE_COLS_DEF,
    parameter int VIEW_LINES   = tslb_pkg::VIEW_LINES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tslb_pkg::t_cmd                      i_cmd,
    input  tslb_pkg::t_op                       i_op,
    input  logic [7:0]                          i_rx_char,
    input  logic                                i_rx_error,
    input  logic                                i_view_row,
    input  logic [3:0]                          i_view_col,
    output logic [tslb_pkg::OUT_DATA_W-1:0]     o_out_data
);

    localparam int LW     = $clog2(BUFFER_LINES);
    localparam int CW     = $clog2(LINE_COLS);
    localparam int FW     = $clog2(LINE_COLS + 1);
    localparam int UW     = $clog2(BUFFER_LINES + 1);
    localparam int CDEPTH = BUFFER_LINES << CW;

    logic [LW-1:0]           r_oldest, n_oldest;
    logic [LW-1:0]           r_newest, n_newest;
    logic [LW-1:0]           r_top, n_top;
    logic [UW-1:0]           r_used, n_used;
    logic [FW-1:0]           r_wcol, n_wcol;
    logic [BUFFER_LINES-1:0] r_valid, n_valid;

    logic                    w_char_we;
    logic                    w_fill_we;
    logic [LW-1:0]           w_wline;
    logic [CW-1:0]           w_wcol_addr;
    logic [FW-1:0]           w_fill_wdata;
    logic [LW-1:0]           w_rline;
    logic [7:0]              w_char_q;
    logic [FW-1:0]           w_fill_q;
    logic                    w_at_new;
    logic                    w_at_old;
    logic                    w_inrange;

    logic [3:0]              r_vcol;
    logic                    r_inrange;
    logic                    r_lvalid;
    logic                    r_at_new;
    logic                    r_at_old;
    logic [tslb_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [FW-1:0]           w_fill_eff;
    logic [7:0]              w_cell;

    function automatic logic [LW-1:0] f_inc(input logic [LW-1:0] x);
        return (x == LW'(BUFFER_LINES - 1)) ? '0 : x + LW'(1);
    endfunction

    function automatic logic [LW-1:0] f_dec(input logic [LW-1:0] x);
        return (x == '0) ? LW'(BUFFER_LINES - 1) : x - LW'(1);
    endfunction

    // small step forward, k below the ring size
    function automatic logic [LW-1:0] f_add(input logic [LW-1:0] x, input logic [2:0] k);
        logic [LW:0] s;
        s = {1'b0, x} + (LW+1)'(k);
        if (s >= (LW+1)'(BUFFER_LINES)) begin
            s = s - (LW+1)'(BUFFER_LINES);
        end
        return s[LW-1:0];
    endfunction

    function automatic logic [LW-1:0] f_sub(input logic [LW-1:0] x, input logic [2:0] k);
        logic [LW:0] s;
        if ({1'b0, x} >= (LW+1)'(k)) begin
            s = {1'b0, x} - (LW+1)'(k);
        end else begin
            s = {1'b0, x} + (LW+1)'(BUFFER_LINES) - (LW+1)'(k);
        end
        return s[LW-1:0];
    endfunction

    assign w_at_new  = (r_newest == f_add(r_top, 3'(VIEW_LINES - 1)));
    assign w_at_old  = (r_oldest == r_top);
    assign w_rline   = f_add(r_top, {2'b00, i_view_row});
    assign w_inrange = (3'(i_view_row) < 3'(VIEW_LINES)) && (7'(i_view_col) < 7'(LINE_COLS));

    always_comb begin
        logic [LW-1:0] v_top;
        logic [LW-1:0] v_old;
        logic [LW-1:0] v_line;
        logic [FW-1:0] v_col;
        logic [UW-1:0] v_used;
        v_top  = r_top;
        v_old  = r_oldest;
        v_line = r_newest;
        v_col  = r_wcol;
        v_used = r_used;

        n_oldest     = r_oldest;
        n_newest     = r_newest;
        n_top        = r_top;
        n_used       = r_used;
        n_wcol       = r_wcol;
        n_valid      = r_valid;
        w_char_we    = 1'b0;
        w_fill_we    = 1'b0;
        w_wline      = r_newest;
        w_wcol_addr  = CW'(r_wcol);
        w_fill_wdata = r_wcol;

        if (i_cmd.upd) begin
            case (i_op)
                tslb_pkg::OP_RX: begin
                    if (!i_rx_error && (i_rx_char != tslb_pkg::CH_CR)) begin
                        // current line full: open the next one first
                        if (r_wcol >= FW'(LINE_COLS)) begin
                            if (r_oldest == f_inc(r_newest)) begin
                                if (r_top == r_oldest) begin
                                    v_top = f_inc(r_top);
                                end
                                v_old = f_inc(r_oldest);
                            end
                            if (r_newest == f_add(v_top, 3'(VIEW_LINES - 1))) begin
                                v_top = f_inc(v_top);
                            end
                            v_line = f_inc(r_newest);
                            n_valid[v_line] = 1'b0;
                            v_col = '0;
                            if (r_used < UW'(BUFFER_LINES)) begin
                                v_used = r_used + UW'(1);
                            end
                        end
                        if (i_rx_char == tslb_pkg::CH_LF) begin
                            v_col = FW'(LINE_COLS);
                        end else begin
                            w_char_we       = 1'b1;
                            w_fill_we       = 1'b1;
                            w_wline         = v_line;
                            w_wcol_addr     = CW'(v_col);
                            v_col           = v_col + FW'(1);
                            w_fill_wdata    = v_col;
                            n_valid[v_line] = 1'b1;
                        end
                        n_top    = v_top;
                        n_oldest = v_old;
                        n_newest = v_line;
                        n_wcol   = v_col;
                        n_used   = v_used;
                    end
                end
                tslb_pkg::OP_UP: begin
                    if (!w_at_old && (r_used > UW'(VIEW_LINES))) begin
                        n_top = f_dec(r_top);
                    end
                end
                tslb_pkg::OP_DOWN: begin
                    if (!w_at_new && (r_used > UW'(VIEW_LINES))) begin
                        n_top = f_inc(r_top);
                    end
                end
                tslb_pkg::OP_END: begin
                    n_top = f_sub(r_newest, 3'(VIEW_LINES - 1));
                end
                tslb_pkg::OP_CLEAR: begin
                    n_valid  = '0;
                    n_oldest = '0;
                    n_newest = '0;
                    n_top    = '0;
                    n_used   = UW'(1);
                    n_wcol   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_newest <= '0;
            r_top    <= '0;
            r_used   <= UW'(1);
            r_wcol   <= '0;
            r_valid  <= '0;
        end else begin
            r_oldest <= n_oldest;
            r_newest <= n_newest;
            r_top    <= n_top;
            r_used   <= n_used;
            r_wcol   <= n_wcol;
            r_valid  <= n_valid;
        end
    end

    // read context, held while the ram answers
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_vcol    <= i_view_col;
            r_inrange <= w_inrange;
            r_lvalid  <= r_valid[w_rline];
            r_at_new  <= w_at_new;
            r_at_old  <= w_at_old;
        end
    end

    tslb_ram #(
        .WIDTH (8),
        .DEPTH (CDEPTH)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (w_char_we),
        .i_waddr ({w_wline, w_wcol_addr}),
        .i_wdata (i_rx_char),
        .i_re    (i_cmd.rd_issue),
        .i_raddr ({w_rline, CW'(i_view_col)}),
        .o_rdata (w_char_q)
    );

    tslb_ram #(
        .WIDTH (FW),
        .DEPTH (BUFFER_LINES)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (w_fill_we),
        .i_waddr (w_wline),
        .i_wdata (w_fill_wdata),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (w_rline),
        .o_rdata (w_fill_q)
    );

    // a line with no valid bit has an empty fill count
    assign w_fill_eff = r_lvalid ? w_fill_q : '0;
    assign w_cell = (r_inrange && ({{FW{1'b0}}, r_vcol} < {4'b0000, w_fill_eff}))
                  ? w_char_q : tslb_pkg::CH_SPACE;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {6'b000000, r_at_old, r_at_new, w_cell};
        end
    end

    assign o_out_data = r_out_data;

endmodule

### rtl/text_scrollback_line_buffer_core.sv
// text scrollback line buffer: a read-cell word is read from the character ram at the
// accepting edge, then loaded into the output register once the output is free, and the
// input is blocked until that load; every other op is accepted back to back.
// output stalls hold a read between the ram read register and the output register.
// reset: synchronous, active low; store empty at once through per-line valid bits.
// depends on tslb_pkg, tslb_ctrl, tslb_dpath
module text_scrollback_line_buffer_core #(
    parameter int BUFFER_LINES = tslb_pkg::BUFFER_LINES_DEF,
    parameter int LINE_COLS    = tslb_pkg::LINE_COLS_DEF,
    parameter int VIEW_LINES   = tslb_pkg::VIEW_LINES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // rx_char[7:0], rx_error[8], view_row[9], view_col[13:10], zero above
    input  logic [tslb_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // op[2:0]
    input  logic [tslb_pkg::IN_USER_W-1:0]    i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // cell_char[7:0], at_newest[8], at_oldest[9], zero above
    output logic [tslb_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    tslb_pkg::t_cmd w_cmd;
    tslb_pkg::t_op  w_op;

    assign w_op = tslb_pkg::t_op'(i_s_tuser);

    tslb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (w_op),
        .i_m_tready (i_m_tready),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd)
    );

    tslb_dpath #(
        .BUFFER_LINES (BUFFER_LINES),
        .LINE_COLS    (LINE_COLS),
        .VIEW_LINES   (VIEW_LINES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_op       (w_op),
        .i_rx_char  (i_s_tdata[7:0]),
        .i_rx_error (i_s_tdata[8]),
        .i_view_row (i_s_tdata[9]),
        .i_view_col (i_s_tdata[13:10]),
        .o_out_data (o_m_tdata)
    );

endmodule

### rtl/tslb_checker.sv
// port-level checks for the text scrollback line buffer, bound to the top level
// depends on tslb_pkg and the assertion macro header
`include "text_scrollback_line_buffer_core_macros.svh"

module tslb_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              o_s_tready,
    input  logic [tslb_pkg::IN_USER_W-1:0]    i_s_tuser,
    input  logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [tslb_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    logic w_read_acc;

    assign w_read_acc = i_s_tvalid && o_s_tready && (i_s_tuser == tslb_pkg::OP_READ);

    // stalled result word holds
    `TSLB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
                      o_m_tvalid && $stable(o_m_tdata))

    // a fresh result only ever follows an accepted read
    `TSLB_ASSERT_SAME(a_out_from_read, i_clk, i_rst_n, $rose(o_m_tvalid), $past(w_read_acc, 2))

    // input blocked while a read is in flight
    `TSLB_ASSERT_NEXT(a_read_blocks, i_clk, i_rst_n, w_read_acc, !o_s_tready)

    // padding bits stay clear
    `TSLB_ASSERT_SAME(a_out_pad, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[15:10] == 6'b000000)

endmodule

bind text_scrollback_line_buffer_core tslb_checker u_tslb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

### verif/text_scrollback_line_buffer_core_test.sv
// self-checking testbench for text_scrollback_line_buffer_core: directed and random words
// against an in-bench scrollback predictor, results checked in order
// depends on tslb_pkg and the core rtl
`timescale 1ns / 100ps

module text_scrollback_line_buffer_core_test;

    localparam int NUM_LINES  = tslb_pkg::BUFFER_LINES_DEF;
    localparam int NUM_COLS   = tslb_pkg::LINE_COLS_DEF;
    localparam int NUM_VIEW   = tslb_pkg::VIEW_LINES_DEF;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_WORDS = 1880;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] chr;
        logic       newest_shown;
        logic       oldest_shown;
    } t_cell_read;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    // rx_char[7:0], rx_error[8], view_row[9], view_col[13:10], zero above
    logic [tslb_pkg::IN_DATA_W-1:0]  i_s_tdata = '0;
    // op[2:0]
    logic [tslb_pkg::IN_USER_W-1:0]  i_s_tuser = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    // cell_char[7:0], at_newest[8], at_oldest[9], zero above
    logic [tslb_pkg::OUT_DATA_W-1:0] o_m_tdata;

    // scrollback shadow state
    logic [7:0] line_text [NUM_LINES][NUM_COLS];
    int         line_len [NUM_LINES];
    int         oldest_idx;
    int         newest_idx;
    int         top_idx;
    int         used_lines;
    int         cursor_col;

    t_cell_read pending_reads[$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    bit         calm = 1'b0;

    text_scrollback_line_buffer_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int ring_fwd(int line, int n);
        return (line + n % NUM_LINES) % NUM_LINES;
    endfunction

    function automatic int ring_back(int line, int n);
        return (line + NUM_LINES - n % NUM_LINES) % NUM_LINES;
    endfunction

    function automatic bit newest_in_view();
        return newest_idx == ring_fwd(top_idx, NUM_VIEW - 1);
    endfunction

    function automatic void wipe_scrollback();
        foreach (line_len[i]) line_len[i] = 0;
        oldest_idx = 0;
        newest_idx = 0;
        top_idx    = 0;
        used_lines = 1;
        cursor_col = 0;
    endfunction

    function automatic void start_new_line();
        if (oldest_idx == ring_fwd(newest_idx, 1)) begin
            // ring full: drop the oldest line, dragging the view along if it sat on it
            if (oldest_idx == top_idx)
                top_idx = ring_fwd(top_idx, 1);
            line_len[oldest_idx] = 0;
            oldest_idx = ring_fwd(oldest_idx, 1);
        end
        if (newest_in_view())
            top_idx = ring_fwd(top_idx, 1);
        newest_idx = ring_fwd(newest_idx, 1);
        line_len[newest_idx] = 0;
        cursor_col = 0;
        if (used_lines < NUM_LINES)
            used_lines++;
    endfunction

    function automatic void apply_word(logic [2:0] op, logic [7:0] ch, logic err,
                                       logic row, logic [3:0] col);
        t_cell_read rd;
        int         line;
        case (op)
            tslb_pkg::OP_RX: begin
                if (!err && ch != tslb_pkg::CH_CR) begin
                    if (cursor_col >= NUM_COLS)
                        start_new_line();
                    if (ch == tslb_pkg::CH_LF) begin
                        cursor_col = NUM_COLS;
                    end else begin
                        line_text[newest_idx][cursor_col] = ch;
                        cursor_col++;
                        line_len[newest_idx] = cursor_col;
                    end
                end
            end
            tslb_pkg::OP_UP: begin
                if (oldest_idx != top_idx && used_lines > NUM_VIEW)
                    top_idx = ring_back(top_idx, 1);
            end
            tslb_pkg::OP_DOWN: begin
                if (!newest_in_view() && used_lines > NUM_VIEW)
                    top_idx = ring_fwd(top_idx, 1);
            end
            tslb_pkg::OP_END: top_idx = ring_back(newest_idx, NUM_VIEW - 1);
            tslb_pkg::OP_CLEAR: wipe_scrollback();
            tslb_pkg::OP_READ: begin
                rd.chr = tslb_pkg::CH_SPACE;
                if (int'(row) < NUM_VIEW && int'(col) < NUM_COLS) begin
                    line = ring_fwd(top_idx, int'(row));
                    if (int'(col) < line_len[line])
                        rd.chr = line_text[line][col];
                end
                rd.newest_shown = newest_in_view();
                rd.oldest_shown = (oldest_idx == top_idx);
                pending_reads.push_back(rd);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // called just after a rising edge; returns at the edge where the word is taken
    task automatic send_word(logic [2:0] op, logic [7:0] ch = 8'h00, logic err = 1'b0,
                             logic row = 1'b0, logic [3:0] col = 4'h0);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 11)
            gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {2'b00, col, row, err, ch};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        apply_word(op, ch, err, row, col);
    endtask

    // output side: random back-pressure, then check each word against the oldest read
    always @(posedge i_clk) begin
        t_cell_read want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_reads.size() == 0) begin
                report_mismatch("unexpected word", 0, o_m_tdata);
            end else begin
                want = pending_reads.pop_front();
                if (o_m_tdata[7:0] !== want.chr)
                    report_mismatch("cell_char", want.chr, o_m_tdata[7:0]);
                if (o_m_tdata[8] !== want.newest_shown)
                    report_mismatch("at_newest", want.newest_shown, o_m_tdata[8]);
                if (o_m_tdata[9] !== want.oldest_shown)
                    report_mismatch("at_oldest", want.oldest_shown, o_m_tdata[9]);
            end
        end
        i_m_tready <= calm || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic test_reset_view();
        send_word(tslb_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 4'h0);
        send_word(tslb_pkg::OP_READ, 8'hFF, 1'b1, 1'b1, 4'hF);
    endtask

    task automatic test_line_editing();
        send_word(tslb_pkg::OP_RX, 8'h41);
        send_word(tslb_pkg::OP_RX, 8'hFF);
        send_word(tslb_pkg::OP_RX, 8'h00);
        send_word(tslb_pkg::OP_RX, 8'h5A, 1'b1);      // line error, dropped
        send_word(tslb_pkg::OP_RX, tslb_pkg::CH_CR);
        send_word(tslb_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 4'h0);
        send_word(tslb_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 4'h2);
        send_word(tslb_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 4'h3);
        send_word(tslb_pkg::OP_RX, tslb_pkg::CH_LF);
        send_word(tslb_pkg::OP_RX, tslb_pkg::CH_LF);  // empty line between
        send_word(tslb_pkg::OP_RX, 8'h71);            // opens a line, view follows
        send_word(tslb_pkg::OP_READ, 8'h00, 1'b0, 1'b1, 4'h0);
    endtask

    task automatic test_scrolling();
        send_word(tslb_pkg::OP_UP);
        send_word(tslb_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 4'h1);
        send_word(tslb_pkg::OP_UP);                   // already at the oldest line
        send_word(tslb_pkg::OP_DOWN);
        send_word(tslb_pkg::OP_DOWN);                 // already at the newest line
        send_word(tslb_pkg::OP_UP);
        send_word(tslb_pkg::OP_END);
        send_word(tslb_pkg::OP_READ, 8'h00, 1'b0, 1'b1, 4'h0);
    endtask

    task automatic test_spare_and_clear();
        send_word(OP_SPARE_LO, 8'hA5, 1'b1, 1'b1, 4'hA);
        send_word(OP_SPARE_HI, 8'h5A, 1'b0, 1'b0, 4'h5);
        send_word(tslb_pkg::OP_CLEAR);
        send_word(tslb_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 4'h0);
    endtask

    task automatic test_random_traffic();
        int         pick;
        logic [2:0] op;
        logic [7:0] ch;
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            calm = (k >= 700 && k < 1000);
            pick = $urandom_range(0, 999);
            if (pick < 520)
                op = tslb_pkg::OP_RX;
            else if (pick < 790)
                op = tslb_pkg::OP_READ;
            else if (pick < 860)
                op = tslb_pkg::OP_UP;
            else if (pick < 930)
                op = tslb_pkg::OP_DOWN;
            else if (pick < 975)
                op = tslb_pkg::OP_END;
            else if (pick < 987)
                op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
            else if (pick < 990)
                op = tslb_pkg::OP_CLEAR;
            else
                op = tslb_pkg::OP_RX;
            // newlines often enough to wrap the ring between clears
            pick = $urandom_range(0, 99);
            if (pick < 12)
                ch = tslb_pkg::CH_LF;
            else if (pick < 16)
                ch = tslb_pkg::CH_CR;
            else
                ch = 8'($urandom_range(0, 255));
            send_word(op, ch, $urandom_range(0, 99) < 5, 1'($urandom_range(0, 1)),
                      4'($urandom_range(0, 15)));
        end
        calm = 1'b0;
    endtask

    initial begin
        wipe_scrollback();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_view();
        test_line_editing();
        test_scrolling();
        test_spare_and_clear();
        test_random_traffic();
        i_s_tvalid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_reads.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
